### rtl/srtv_pkg.sv
// ----------------------------------------------------------------------------
// srtv_pkg
// Types, codes and the timestamp pattern stepper shared by the validator.
// ----------------------------------------------------------------------------
package srtv_pkg;

   // request word
   typedef struct packed {
      logic [7:0] input_byte;
      logic       end_of_input;
   } req_type;

   // response word
   typedef struct packed {
      logic [2:0]  line_kind;
      logic [23:0] line_number;
      logic [23:0] subtitle_count;
      logic [3:0]  error_code;
      logic        finished;
   } rsp_type;

   // classified byte operations
   localparam logic [1:0] OP_CONTENT = 2'd0;
   localparam logic [1:0] OP_NEWLINE = 2'd1;
   localparam logic [1:0] OP_CR      = 2'd2;
   localparam logic [1:0] OP_EOI     = 2'd3;

   // word passed from front to back
   typedef struct packed {
      logic [1:0] op;
      logic [1:0] replay;
      logic [7:0] data;
   } item_type;

   // parser phases
   localparam logic [2:0] PH_NUMBER = 3'd0;
   localparam logic [2:0] PH_STAMP  = 3'd1;
   localparam logic [2:0] PH_TEXT   = 3'd2;
   localparam logic [2:0] PH_TRAIL  = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   // line kinds
   localparam logic [2:0] KIND_NUMBER = 3'd0;
   localparam logic [2:0] KIND_STAMP  = 3'd1;
   localparam logic [2:0] KIND_TEXT   = 3'd2;
   localparam logic [2:0] KIND_SEP    = 3'd3;
   localparam logic [2:0] KIND_TRAIL  = 3'd4;
   localparam logic [2:0] KIND_FINAL  = 3'd5;

   // error codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_EMPTY     = 4'd1;
   localparam logic [3:0] ERR_BLANK     = 4'd2;
   localparam logic [3:0] ERR_NUMBER    = 4'd3;
   localparam logic [3:0] ERR_NO_STAMP  = 4'd4;
   localparam logic [3:0] ERR_STAMP     = 4'd5;
   localparam logic [3:0] ERR_NO_TEXT   = 4'd6;
   localparam logic [3:0] ERR_UNCLOSED  = 4'd7;
   localparam logic [3:0] ERR_TOO_LONG  = 4'd8;

   // characters
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_FIVE  = 8'h35;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // byte order mark
   localparam logic [7:0] BOM_0 = 8'hEF;
   localparam logic [7:0] BOM_1 = 8'hBB;
   localparam logic [7:0] BOM_2 = 8'hBF;

   // timestamp stepper positions
   localparam logic [4:0] ST_SECOND  = 5'd17;
   localparam logic [4:0] ST_SHORT   = 5'd28;
   localparam logic [4:0] ST_LONG    = 5'd29;
   localparam logic [4:0] ST_FAIL    = 5'd31;

   // advance the timestamp pattern by one byte
   function automatic logic [4:0] stamp_next(input logic [4:0] s, input logic [7:0] b);
      logic [4:0] k;
      logic       dig;
      logic       ok;
      logic [4:0] r;
      dig = (b >= CH_ZERO) && (b <= CH_NINE);
      k   = (s >= ST_SECOND) ? s - ST_SECOND : s;
      case (k)
         5'd2, 5'd5: ok = (b == CH_COLON);
         5'd8:       ok = (b == CH_COMMA);
         5'd3, 5'd6: ok = (b >= CH_ZERO) && (b <= CH_FIVE);
         default:    ok = dig;
      endcase
      if (s <= 5'd10 || (s >= ST_SECOND && s <= 5'd27)) begin
         r = ok ? s + 5'd1 : ST_FAIL;
      end else begin
         case (s)
            5'd11:   r = dig ? 5'd12 : ((b == CH_SPACE) ? 5'd13 : ST_FAIL);
            5'd12:   r = (b == CH_SPACE) ? 5'd13 : ST_FAIL;
            5'd13:   r = (b == CH_DASH) ? 5'd14 : ST_FAIL;
            5'd14:   r = (b == CH_DASH) ? 5'd15 : ST_FAIL;
            5'd15:   r = (b == CH_GT) ? 5'd16 : ST_FAIL;
            5'd16:   r = (b == CH_SPACE) ? ST_SECOND : ST_FAIL;
            5'd28:   r = dig ? ST_LONG : ST_FAIL;
            default: r = ST_FAIL;
         endcase
      end
      return r;
   endfunction

endpackage

### rtl/srtv_fifo.sv
// ----------------------------------------------------------------------------
// srtv_fifo
// Two-entry queue that decouples producer and consumer stalls.
// ----------------------------------------------------------------------------
module srtv_fifo #(
   parameter int WIDTH = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_in    = do_push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/srtv_front.sv
// ----------------------------------------------------------------------------
// srtv_front
// Accepts raw bytes, strips a leading byte order mark and classifies bytes.
// ----------------------------------------------------------------------------
module srtv_front
   import srtv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     item_valid,
   input  logic     item_ready,
   output item_type item_data
);

   logic [1:0] bom_ff, bom_in;
   logic [7:0] bom_byte;
   logic       match;
   logic       useful;
   logic       accept;

   assign req_ready = item_ready;
   assign accept    = req_valid && req_ready;

   // expected mark byte at this position
   always_comb begin
      case (bom_ff)
         2'd0:    bom_byte = BOM_0;
         2'd1:    bom_byte = BOM_1;
         default: bom_byte = BOM_2;
      endcase
   end

   // classification
   always_comb begin
      match            = !req_data.end_of_input && (bom_ff != 2'd3) &&
                         (req_data.input_byte == bom_byte);
      item_data.data   = req_data.input_byte;
      item_data.replay = (bom_ff == 2'd3) ? 2'd0 : bom_ff;
      if (req_data.end_of_input) begin
         item_data.op = OP_EOI;
      end else if (req_data.input_byte == CH_LF) begin
         item_data.op = OP_NEWLINE;
      end else if (req_data.input_byte == CH_CR) begin
         item_data.op = OP_CR;
      end else begin
         item_data.op = OP_CONTENT;
      end
      useful     = !match && !(item_data.op == OP_CR && item_data.replay == 2'd0);
      item_valid = req_valid && useful;
      bom_in     = bom_ff;
      if (accept) begin
         bom_in = match ? bom_ff + 2'd1 : 2'd3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bom_ff <= 2'd0;
      end else begin
         bom_ff <= bom_in;
      end
   end

endmodule

### rtl/srtv_back.sv
// ----------------------------------------------------------------------------
// srtv_back
// Line state machine: tracks columns, checks lines and produces responses.
// ----------------------------------------------------------------------------
module srtv_back
   import srtv_pkg::*;
#(
   parameter int COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] max_len,
   input  logic        item_valid,
   output logic        item_ready,
   input  item_type    item_data,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_data
);

   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

   logic [2:0]            phase_ff, phase_in;
   logic [11:0]           col_ff, col_in;
   logic [4:0]            stamp_ff, stamp_in;
   logic                  ok_ff, ok_in;
   logic                  long_ff, long_in;
   logic [COUNT_BITS-1:0] li_ff, li_in;
   logic [COUNT_BITS-1:0] subs_ff, subs_in;
   logic                  text_ff, text_in;
   logic [COUNT_BITS-1:0] pend_ff, pend_in;
   logic [3:0]            err_ff, err_in;
   logic [COUNT_BITS-1:0] eline_ff, eline_in;
   logic                  fin_ff, fin_in;

   logic                  fire, active, blank, do_finish, first;
   logic [11:0]           col1;
   logic                  long1;
   logic [2:0]            expect_kind;
   logic [2:0]            kind;
   logic [3:0]            err_v;
   logic [COUNT_BITS-1:0] line_v;
   logic [COUNT_BITS-1:0] subs_v;
   logic [COUNT_BITS+23:0] line_wide, subs_wide;

   assign fire       = item_valid && out_ready;
   assign item_ready = out_ready && (item_data.op != OP_EOI || fin_ff);
   assign active     = (err_ff == ERR_NONE) && (phase_ff != PH_DONE);
   assign line_wide  = {24'd0, line_v};
   assign subs_wide  = {24'd0, subs_v};

   always_comb begin
      phase_in  = phase_ff;
      col_in    = col_ff;
      stamp_in  = stamp_ff;
      ok_in     = ok_ff;
      long_in   = long_ff;
      li_in     = li_ff;
      subs_in   = subs_ff;
      text_in   = text_ff;
      pend_in   = pend_ff;
      err_in    = err_ff;
      eline_in  = eline_ff;
      fin_in    = fin_ff;
      out_valid = 1'b0;
      kind      = KIND_FINAL;
      err_v     = err_ff;
      line_v    = li_ff;
      blank     = 1'b0;
      first     = 1'b0;
      do_finish = 1'b0;
      col1      = col_ff;
      long1     = long_ff;
      expect_kind = (phase_ff == PH_STAMP) ? KIND_STAMP :
                    ((phase_ff == PH_TEXT) ? KIND_TEXT : KIND_NUMBER);

      if (fire && fin_ff) begin
         // final status
         fin_in    = 1'b0;
         out_valid = 1'b1;
         kind      = KIND_FINAL;
         line_v    = (err_ff != ERR_NONE) ? eline_ff : li_ff;
      end else if (fire) begin
         if (item_data.op == OP_EOI) begin
            fin_in   = 1'b1;
            phase_in = PH_DONE;
         end
         if (active) begin
            // replay of a partly matched mark, only at file start
            if (item_data.replay != 2'd0) begin
               long1 = {10'd0, item_data.replay} > max_len;
               col1  = long1 ? max_len : {10'd0, item_data.replay};
               if (phase_ff == PH_NUMBER || phase_ff == PH_TRAIL) begin
                  ok_in = 1'b0;
               end
            end
            col_in  = col1;
            long_in = long1;
            // ordinary content byte
            if (item_data.op == OP_CONTENT) begin
               first = (col1 == 12'd0) && !long1;
               if (col1 >= max_len) begin
                  long_in = 1'b1;
               end else begin
                  col_in = col1 + 12'd1;
               end
               if (phase_ff == PH_NUMBER || phase_ff == PH_TRAIL) begin
                  if (first ? !(item_data.data >= CH_ONE && item_data.data <= CH_NINE)
                            : !(item_data.data >= CH_ZERO && item_data.data <= CH_NINE)) begin
                     ok_in = 1'b0;
                  end
               end else if (phase_ff == PH_STAMP) begin
                  stamp_in = stamp_next(stamp_ff, item_data.data);
               end
            end
            // line completion
            do_finish = (item_data.op == OP_NEWLINE) ||
                        (item_data.op == OP_EOI && (col1 != 12'd0 || long1));
            if (do_finish) begin
               blank = (col1 == 12'd0) && !long1;
               if (long1) begin
                  err_in = ERR_TOO_LONG; eline_in = li_ff;
               end else begin
                  case (phase_ff)
                     PH_NUMBER: begin
                        if (blank) begin
                           if (subs_ff == '0) begin
                              err_in = ERR_BLANK; eline_in = li_ff;
                           end else begin
                              pend_in  = li_ff;
                              phase_in = PH_TRAIL;
                           end
                        end else if (ok_in) begin
                           phase_in = PH_STAMP;
                        end else begin
                           err_in = ERR_NUMBER; eline_in = li_ff;
                        end
                     end
                     PH_TRAIL: begin
                        if (!blank) begin
                           err_in = ERR_BLANK; eline_in = pend_ff;
                        end
                     end
                     PH_STAMP: begin
                        if (blank) begin
                           err_in = ERR_NO_STAMP; eline_in = li_ff;
                        end else if (stamp_ff == ST_SHORT || stamp_ff == ST_LONG) begin
                           phase_in = PH_TEXT;
                        end else begin
                           err_in = ERR_STAMP; eline_in = li_ff;
                        end
                     end
                     default: begin
                        if (blank) begin
                           if (!text_ff) begin
                              err_in = ERR_NO_TEXT; eline_in = li_ff;
                           end else begin
                              subs_in  = (subs_ff == CMAX) ? subs_ff : subs_ff + 1'b1;
                              text_in  = 1'b0;
                              phase_in = PH_NUMBER;
                           end
                        end else begin
                           text_in = 1'b1;
                        end
                     end
                  endcase
               end
               out_valid = 1'b1;
               if (err_in != ERR_NONE) begin
                  kind   = expect_kind;
                  line_v = eline_in;
               end else begin
                  kind   = blank ? ((expect_kind == KIND_TEXT) ? KIND_SEP : KIND_TRAIL)
                                 : expect_kind;
                  line_v = li_ff;
                  li_in  = (li_ff == CMAX) ? li_ff : li_ff + 1'b1;
               end
               col_in   = 12'd0;
               stamp_in = 5'd0;
               ok_in    = 1'b1;
               long_in  = 1'b0;
            end
            // line word carries the error as of the line, before end of file checks
            err_v = err_in;
            // end of file checks
            if (item_data.op == OP_EOI && err_in == ERR_NONE) begin
               if (li_in == '0) begin
                  err_in = ERR_EMPTY; eline_in = '0;
               end else if (phase_in == PH_STAMP || phase_in == PH_TEXT ||
                            (phase_in == PH_NUMBER && subs_in == '0)) begin
                  err_in = ERR_UNCLOSED; eline_in = li_in - 1'b1;
               end
            end
            if (item_data.op == OP_EOI) begin
               phase_in = PH_DONE;
            end
         end
      end
      subs_v                  = subs_in;
      out_data.line_kind      = kind;
      out_data.line_number    = line_wide[23:0];
      out_data.subtitle_count = subs_wide[23:0];
      out_data.error_code     = err_v;
      out_data.finished       = (fire && fin_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NUMBER;
         col_ff   <= 12'd0;
         stamp_ff <= 5'd0;
         ok_ff    <= 1'b1;
         long_ff  <= 1'b0;
         li_ff    <= '0;
         subs_ff  <= '0;
         text_ff  <= 1'b0;
         pend_ff  <= '0;
         err_ff   <= ERR_NONE;
         eline_ff <= '0;
         fin_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         stamp_ff <= stamp_in;
         ok_ff    <= ok_in;
         long_ff  <= long_in;
         li_ff    <= li_in;
         subs_ff  <= subs_in;
         text_ff  <= text_in;
         pend_ff  <= pend_in;
         err_ff   <= err_in;
         eline_ff <= eline_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

### rtl/srt_subtitle_validator_core.sv
// ----------------------------------------------------------------------------
// srt_subtitle_validator_core
// SubRip stream checker: one byte per request word, one response per line.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one file byte per word, or an end-of-input marker word.
//   rsp_*  : one word per completed line, plus a final status word (finished
//            set) for each end-of-input marker.
//   csr_*  : writes max_line_length; always ready, write only while idle.
// Timing
//   A byte is taken every cycle while the front queue has room. Its item
//   is registered in the front queue, then the line unit writes its response
//   into the response queue, from which it leaves. An end-of-input word stays
//   in the line unit for its finishing line and status, holding it longer.
// Reset
//   Synchronous; clears all line state, queues and the sticky error, and
//   sets max_line_length to 254.
// Stall
//   When rsp_ready is low the response queue fills, the line unit halts,
//   then the front queue fills and req_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module srt_subtitle_validator_core
   import srtv_pkg::*;
#(
   parameter int COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_data
);

   logic [11:0] max_len_ff, max_len_in;
   logic        f_valid, f_ready;
   item_type    f_data;
   logic        q_valid, q_ready;
   item_type    q_data;
   logic        b_valid, b_ready;
   rsp_type     b_data;

   // configuration register
   assign csr_ready  = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= 12'd254;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // byte classifier
   srtv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item_data  (f_data)
   );

   // front to back queue
   srtv_fifo #(.WIDTH($bits(item_type))) u_item_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   // line unit
   srtv_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_len    (max_len_ff),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item_data  (q_data),
      .out_valid  (b_valid),
      .out_ready  (b_ready),
      .out_data   (b_data)
   );

   // response queue
   srtv_fifo #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (b_valid),
      .push_ready (b_ready),
      .push_data  (b_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data)
   );

   // a finished word is always a final status
   a_fin_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finished |-> rsp_data.line_kind == KIND_FINAL)
      else $error("finished word without final kind");

   // the line unit only emits when the response queue has room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      b_valid |-> b_ready)
      else $error("response queue overflow");

   // the queues are empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_valid)
      else $error("queue not empty after reset");

endmodule

### tb/sv/srt_subtitle_validator_core_test.sv
// ----------------------------------------------------------------------------
// srt_subtitle_validator_core_test
// Self-checking bench for the SubRip stream checker. A driver sends one
// file as byte words, with the line limit changed between phases. A line
// predictor computes each response, and a monitor checks every response
// word field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module srt_subtitle_validator_core_test;
   import srtv_pkg::*;

   localparam logic [23:0] COUNT_TOP = 24'hFFFFFF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_data = 12'd254;

   srt_subtitle_validator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // bench bookkeeping
   req_type byte_q[$];
   rsp_type line_report_q[$];
   int      mismatches = 0;
   bit      idle_on = 1'b1;
   bit      long_hold_req = 1'b0;
   int      req_gap = 0;
   int      rsp_hold = 0;

   // predictor state
   logic [11:0] lim = 12'd254;
   logic [2:0]  ph = PH_NUMBER;
   logic [11:0] col = '0;
   logic [4:0]  spos = '0;
   logic        lok = 1'b1;
   logic        ltl = 1'b0;
   logic [23:0] lidx = '0;
   logic [23:0] nsub = '0;
   logic        tseen = 1'b0;
   logic [23:0] blank_at = '0;
   logic [3:0]  serr = ERR_NONE;
   logic [23:0] eline = '0;
   logic [1:0]  bpos = '0;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [23:0] bump(input logic [23:0] v);
      return (v == COUNT_TOP) ? v : v + 24'd1;
   endfunction

   function automatic logic is_dig(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   function automatic logic [7:0] mark_byte(input logic [1:0] i);
      return (i == 2'd0) ? BOM_0 : ((i == 2'd1) ? BOM_1 : BOM_2);
   endfunction

   // timestamp pattern hh:mm:ss,mm[m] --> hh:mm:ss,mm[m]
   function automatic logic [4:0] stamp_advance(input logic [4:0] s, input logic [7:0] b);
      logic [4:0] k;
      logic       ok;
      logic [4:0] r;
      k = (s >= 5'd17) ? s - 5'd17 : s;
      if (k == 5'd2 || k == 5'd5) ok = (b == CH_COLON);
      else if (k == 5'd8) ok = (b == CH_COMMA);
      else if (k == 5'd3 || k == 5'd6) ok = (b >= CH_ZERO) && (b <= CH_FIVE);
      else ok = is_dig(b);
      r = ST_FAIL;
      if (s <= 5'd10 || (s >= 5'd17 && s <= 5'd27)) begin
         if (ok) r = s + 5'd1;
      end else if (s == 5'd11) begin
         if (is_dig(b)) r = 5'd12;
         else if (b == CH_SPACE) r = 5'd13;
      end else if (s == 5'd12) begin
         if (b == CH_SPACE) r = 5'd13;
      end else if (s == 5'd13 || s == 5'd14) begin
         if (b == CH_DASH) r = s + 5'd1;
      end else if (s == 5'd15) begin
         if (b == CH_GT) r = 5'd16;
      end else if (s == 5'd16) begin
         if (b == CH_SPACE) r = 5'd17;
      end else if (s == ST_SHORT) begin
         if (is_dig(b)) r = ST_LONG;
      end
      return r;
   endfunction

   task automatic push_line_report(input logic [2:0] kind, input logic [23:0] line,
                                   input logic fin);
      line_report_q.push_back('{line_kind: kind, line_number: line, subtitle_count: nsub,
                                error_code: serr, finished: fin});
   endtask

   task automatic flag(input logic [3:0] code, input logic [23:0] line);
      serr  = code;
      eline = line;
   endtask

   task automatic take_content(input logic [7:0] b);
      logic first;
      first = (col == 0) && !ltl;
      if (col >= lim) ltl = 1'b1;
      else col = col + 12'd1;
      if (ph == PH_NUMBER || ph == PH_TRAIL) begin
         if (first ? !(b >= CH_ONE && b <= CH_NINE) : !is_dig(b)) lok = 1'b0;
      end else if (ph == PH_STAMP) begin
         spos = stamp_advance(spos, b);
      end
   endtask

   task automatic flush_mark;
      for (int i = 0; i < bpos; i++) take_content(mark_byte(i[1:0]));
      bpos = 2'd3;
   endtask

   task automatic close_line;
      logic       blank;
      logic [2:0] want;
      blank = (col == 0) && !ltl;
      want  = (ph == PH_STAMP) ? KIND_STAMP : ((ph == PH_TEXT) ? KIND_TEXT : KIND_NUMBER);
      if (ltl) begin
         flag(ERR_TOO_LONG, lidx);
      end else if (ph == PH_NUMBER) begin
         if (blank) begin
            if (nsub == 0) flag(ERR_BLANK, lidx);
            else begin
               blank_at = lidx;
               ph = PH_TRAIL;
            end
         end else if (lok) ph = PH_STAMP;
         else flag(ERR_NUMBER, lidx);
      end else if (ph == PH_TRAIL) begin
         if (!blank) flag(ERR_BLANK, blank_at);
      end else if (ph == PH_STAMP) begin
         if (blank) flag(ERR_NO_STAMP, lidx);
         else if (spos == ST_SHORT || spos == ST_LONG) ph = PH_TEXT;
         else flag(ERR_STAMP, lidx);
      end else begin
         if (blank) begin
            if (!tseen) flag(ERR_NO_TEXT, lidx);
            else begin
               nsub  = bump(nsub);
               tseen = 1'b0;
               ph    = PH_NUMBER;
            end
         end else tseen = 1'b1;
      end
      if (serr != ERR_NONE) push_line_report(want, eline, 1'b0);
      else begin
         push_line_report(blank ? ((want == KIND_TEXT) ? KIND_SEP : KIND_TRAIL) : want,
                          lidx, 1'b0);
         lidx = bump(lidx);
      end
      col  = '0;
      spos = '0;
      lok  = 1'b1;
      ltl  = 1'b0;
   endtask

   // expected responses for one accepted request word
   task automatic predict_lines(input req_type w);
      if (ph == PH_DONE) begin
         if (w.end_of_input)
            push_line_report(KIND_FINAL, (serr != ERR_NONE) ? eline : lidx, 1'b1);
      end else if (!w.end_of_input) begin
         if (serr == ERR_NONE) begin
            if (bpos < 2'd3 && w.input_byte == mark_byte(bpos)) bpos = bpos + 2'd1;
            else begin
               if (bpos < 2'd3) flush_mark();
               if (w.input_byte == CH_LF) close_line();
               else if (w.input_byte != CH_CR) take_content(w.input_byte);
            end
         end
      end else begin
         if (serr == ERR_NONE) begin
            if (bpos < 2'd3) flush_mark();
            if (col != 0 || ltl) close_line();
         end
         if (serr == ERR_NONE) begin
            if (lidx == 0) flag(ERR_EMPTY, '0);
            else if (ph == PH_STAMP || ph == PH_TEXT || (ph == PH_NUMBER && nsub == 0))
               flag(ERR_UNCLOSED, lidx - 24'd1);
         end
         ph = PH_DONE;
         push_line_report(KIND_FINAL, (serr != ERR_NONE) ? eline : lidx, 1'b1);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_lines(req_data);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
               req_data  <= byte_q.pop_front();
               req_valid <= 1'b1;
               if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random and long stalls
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (line_report_q.size() == 0) begin
               report("response word with nothing expected");
            end else begin
               want = line_report_q.pop_front();
               if (rsp_data.line_kind != want.line_kind)
                  report($sformatf("line_kind %0d, want %0d", rsp_data.line_kind,
                                   want.line_kind));
               if (rsp_data.line_number != want.line_number)
                  report($sformatf("line_number %0d, want %0d", rsp_data.line_number,
                                   want.line_number));
               if (rsp_data.subtitle_count != want.subtitle_count)
                  report($sformatf("subtitle_count %0d, want %0d", rsp_data.subtitle_count,
                                   want.subtitle_count));
               if (rsp_data.error_code != want.error_code)
                  report($sformatf("error_code %0d, want %0d", rsp_data.error_code,
                                   want.error_code));
               if (rsp_data.finished != want.finished)
                  report($sformatf("finished %0d, want %0d", rsp_data.finished,
                                   want.finished));
            end
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_hold = 300;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_hold = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // register write channel
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         csr_valid <= 1'b0;
         lim = csr_data;
      end
   end

   task automatic write_limit(input logic [11:0] v);
      @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (csr_valid) @(posedge clock);
   endtask

   // wait for all words out and all responses in, then let the pipe drain
   task automatic settle;
      while (byte_q.size() > 0 || req_valid || line_report_q.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      byte_q.push_back('{input_byte: b, end_of_input: 1'b0});
   endtask

   task automatic send_eoi;
      byte_q.push_back('{input_byte: 8'($urandom), end_of_input: 1'b1});
   endtask

   task automatic send_eol;
      if ($urandom_range(0, 5) == 0) send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_eol();
   endtask

   // free text: any byte but the line breaks
   task automatic send_text(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom);
         while (b == CH_LF || b == CH_CR) b = 8'($urandom);
         send_byte(b);
         if ($urandom_range(0, 15) == 0) send_byte(CH_CR);
      end
      send_eol();
   endtask

   function automatic string rand_time();
      string s;
      s = $sformatf("%0d%0d:%0d%0d:%0d%0d,%0d%0d", $urandom_range(0, 9),
                    $urandom_range(0, 9), $urandom_range(0, 5), $urandom_range(0, 9),
                    $urandom_range(0, 5), $urandom_range(0, 9), $urandom_range(0, 9),
                    $urandom_range(0, 9));
      if ($urandom_range(0, 1)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
      return s;
   endfunction

   task automatic send_subtitle(input int text_max);
      send_line($sformatf("%0d", $urandom_range(0, 3) == 0 ? $urandom_range(1, 999999)
                                                         : $urandom_range(1, 99)));
      send_line({rand_time(), " --> ", rand_time()});
      repeat ($urandom_range(1, 3)) send_text($urandom_range(1, text_max));
      send_eol();
   endtask

   initial begin
      int text_max;
      int ending;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: mark, extreme stamps, extreme bytes, longest limit
      write_limit(12'd4095);
      send_byte(BOM_0);
      send_byte(BOM_1);
      send_byte(BOM_2);
      send_line("1");
      send_line("00:00:00,00 --> 99:59:59,999");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_eol();
      send_text(300);
      send_eol();
      settle();

      // random subtitles with a long receiver stall
      write_limit(12'd254);
      while (byte_q.size() < 100) send_subtitle(24);
      long_hold_req = 1'b1;
      settle();

      // short limit with a line of exactly the limit
      text_max = $urandom_range(30, 60);
      write_limit(12'(text_max));
      while (byte_q.size() < 40) send_subtitle(20);
      send_line("5");
      send_line("10:20:30,400 --> 10:20:31,40");
      send_text(text_max);
      send_eol();
      settle();

      // smallest limit for a one digit number line
      idle_on = 1'b0;
      write_limit(12'd1);
      send_line("9");
      settle();
      write_limit(12'd4095);
      send_line("01:02:03,004 --> 01:02:04,005");
      send_text(5);
      send_eol();
      settle();

      // random way of ending the file
      ending = $urandom_range(0, 7);
      if (ending == 7) begin
         write_limit(12'd2);
         send_line("123");
      end else if (ending == 0) begin
         repeat ($urandom_range(1, 3)) send_eol();
      end else if (ending == 1) begin
         send_eol();
         send_line("42");
      end else if (ending == 2) begin
         send_line($urandom_range(0, 1) ? "012" : "1a");
      end else if (ending == 3) begin
         send_line("7");
         send_eol();
      end else if (ending == 4) begin
         send_line("7");
         send_line("00:60:00,000 --> 00:00:01,000");
      end else if (ending == 5) begin
         send_line("7");
         send_line("00:00:00,000 --> 00:00:01,000");
         send_eol();
      end else begin
         send_line("7");
         send_line("00:00:00,000 --> 00:00:01,000");
         send_byte("x");
      end
      // ignored bytes, final status, then repeated status
      repeat ($urandom_range(3, 8)) send_byte(8'($urandom));
      send_byte(CH_LF);
      send_eoi();
      send_byte(CH_LF);
      send_byte(8'($urandom));
      send_eoi();
      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
rtl/srtv_pkg.sv
rtl/srtv_fifo.sv
rtl/srtv_front.sv
rtl/srtv_back.sv
rtl/srt_subtitle_validator_core.sv
tb/sv/srt_subtitle_validator_core_test.sv
